[hw/rtl/gsst_pkg.sv]
// gsst_pkg: shared types and constants of the gradient stop sorted table
// depends on nothing; used by gradient_stop_sorted_table and its bench
package gsst_pkg;

	localparam int OFFSET_W       = 17;
	localparam int DEF_MAX_STOPS  = 16;
	localparam int DEF_COLOR_BITS = 32;

	localparam logic [OFFSET_W-1:0] OFFSET_ONE = 17'd65536;

	typedef enum logic [2:0] {
		OP_INSERT          = 3'd0,
		OP_REMOVE_AT       = 3'd1,
		OP_REMOVE_RANGE    = 3'd2,
		OP_REMOVE_INTERVAL = 3'd3,
		OP_REMOVE_OFFSET   = 3'd4,
		OP_REMOVE_STOP     = 3'd5,
		OP_INDEX_OF        = 3'd6,
		OP_CLEAR           = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

endpackage

[hw/rtl/gsst_mem.sv]
// gsst_mem: stop memory, one write port and one registered read port
// depends on nothing
module gsst_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 49
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/gradient_stop_sorted_table.sv]
// gradient_stop_sorted_table: gradient stops kept sorted by offset in one memory
// depends on gsst_pkg and gsst_mem
//
// A word is taken when start is high and busy is low. The result comes back
// on status, found_index and stop_count for exactly one cycle while done is
// high; the receiver cannot stall it, so sample it when done is seen. An
// operation that looks up an offset first scans the held stops, one memory
// read a cycle, and passes the decide state; an insert or a removal moves
// stops through the same memory port, and every operation ends in the result
// state. busy stays high through the result state, longest for a full scan
// followed by removing the first stop, and drops for one cycle before the
// next word can be taken. Clear, invalid arguments and full-table words are
// busy for one cycle only, the result cycle. So are empty index ranges. The
// memory is never cleared; only entries below the held count are ever read.
module gradient_stop_sorted_table #(
	parameter int MAX_STOPS  = gsst_pkg::DEF_MAX_STOPS,
	parameter int COLOR_BITS = gsst_pkg::DEF_COLOR_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  gsst_pkg::op_t                     op,
	input  logic [gsst_pkg::OFFSET_W-1:0]     offset,
	input  logic [gsst_pkg::OFFSET_W-1:0]     offset_max,
	input  logic [$clog2(MAX_STOPS+1)-1:0]    first_index,
	input  logic [$clog2(MAX_STOPS+1)-1:0]    end_index,
	input  logic [COLOR_BITS-1:0]             color,
	output logic                              done,
	output gsst_pkg::status_t                 status,
	output logic [$clog2(MAX_STOPS+1)-1:0]    found_index,
	output logic [$clog2(MAX_STOPS+1)-1:0]    stop_count
);
	import gsst_pkg::*;

	localparam int IW = $clog2(MAX_STOPS);
	localparam int CW = $clog2(MAX_STOPS+1);
	localparam int EW = OFFSET_W + COLOR_BITS;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_STOPS);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_DECIDE = 6'b000100,
		S_COPY   = 6'b001000,
		S_SHIFT  = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t                state_q;
	op_t                   op_q;
	logic [OFFSET_W-1:0]   off_q;      // stop offset or interval minimum
	logic [OFFSET_W-1:0]   bound_q;    // upper bound of the le count
	logic [COLOR_BITS-1:0] col_q;
	logic [CW-1:0]         cnt_q;      // held stops
	logic [CW-1:0]         lt_q;       // stops below off_q
	logic [CW-1:0]         le_q;       // stops at or below bound_q
	logic                  mt_found_q;
	logic [CW-1:0]         mt_idx_q;
	logic [CW-1:0]         lo_q;
	logic [CW-1:0]         hi_q;
	logic [CW-1:0]         rd_ptr_q;
	logic [CW-1:0]         wr_ptr_q;
	logic                  rd_vld_q;
	status_t               status_q;
	logic [CW-1:0]         found_q;

	logic                  rd_en;
	logic [IW-1:0]         rd_addr;
	logic [EW-1:0]         rd_data;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [EW-1:0]         wr_data;
	logic [CW-1:0]         src_m1;
	logic [OFFSET_W-1:0]   e_off;
	logic [COLOR_BITS-1:0] e_col;
	logic [CW-1:0]         end_clamp;

	gsst_mem #(
		.DEPTH (MAX_STOPS),
		.WIDTH (EW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign e_off     = rd_data[EW-1 -: OFFSET_W];
	assign e_col     = rd_data[COLOR_BITS-1:0];
	assign src_m1    = rd_ptr_q - CW'(1);
	assign end_clamp = (end_index > cnt_q) ? cnt_q : end_index;

	// read side: scan and compaction walk upward, insert shift walks downward
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_ptr_q[IW-1:0];
		if (state_q == S_SCAN || state_q == S_COPY) begin
			rd_en = (rd_ptr_q < cnt_q);
		end else if (state_q == S_SHIFT) begin
			rd_en   = (rd_ptr_q > lo_q);
			rd_addr = src_m1[IW-1:0];
		end
	end

	// write side: moved entry in the cycle after its read, then the new stop
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_ptr_q[IW-1:0];
		wr_data = rd_data;
		if (state_q == S_COPY) begin
			wr_en = rd_vld_q;
		end else if (state_q == S_SHIFT) begin
			if (rd_vld_q) begin
				wr_en = 1'b1;
			end else if (rd_ptr_q == lo_q) begin
				wr_en   = 1'b1;
				wr_addr = lo_q[IW-1:0];
				wr_data = {off_q, col_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_CLEAR;
			off_q      <= '0;
			bound_q    <= '0;
			col_q      <= '0;
			cnt_q      <= '0;
			lt_q       <= '0;
			le_q       <= '0;
			mt_found_q <= 1'b0;
			mt_idx_q   <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			rd_vld_q   <= 1'b0;
			status_q   <= ST_OK;
			found_q    <= '0;
		end else begin
			rd_vld_q <= rd_en;
			if (rd_en) begin
				rd_ptr_q <= (state_q == S_SHIFT) ? src_m1 : rd_ptr_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q       <= op;
						off_q      <= offset;
						bound_q    <= (op == OP_REMOVE_INTERVAL) ? offset_max : offset;
						col_q      <= color;
						lt_q       <= '0;
						le_q       <= '0;
						mt_found_q <= 1'b0;
						status_q   <= ST_OK;
						found_q    <= MAX_C;
						rd_ptr_q   <= '0;
						case (op)
							OP_INSERT: begin
								if (offset > OFFSET_ONE) begin
									status_q <= ST_INVALID;
									state_q  <= S_DONE;
								end else if (cnt_q >= MAX_C) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_REMOVE_AT: begin
								if (first_index >= cnt_q) begin
									status_q <= ST_INVALID;
									state_q  <= S_DONE;
								end else begin
									lo_q     <= first_index;
									hi_q     <= first_index + CW'(1);
									wr_ptr_q <= first_index;
									rd_ptr_q <= first_index + CW'(1);
									state_q  <= S_COPY;
								end
							end
							OP_REMOVE_RANGE: begin
								if (first_index >= cnt_q) begin
									status_q <= ST_INVALID;
									state_q  <= S_DONE;
								end else if (end_clamp > first_index) begin
									lo_q     <= first_index;
									hi_q     <= end_clamp;
									wr_ptr_q <= first_index;
									rd_ptr_q <= end_clamp;
									state_q  <= S_COPY;
								end else begin
									state_q <= S_DONE;
								end
							end
							OP_REMOVE_INTERVAL: begin
								if (offset > offset_max) begin
									status_q <= ST_INVALID;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_REMOVE_STOP: begin
								if (offset > OFFSET_ONE) begin
									status_q <= ST_INVALID;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_DONE;
							end
							default: begin
								// remove_offset and index_of have no argument check and go straight to the scan
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					// sorted table, so prefix counts give span bounds directly
					if (rd_vld_q) begin
						if (e_off < off_q) begin
							lt_q <= lt_q + CW'(1);
						end
						if (e_off <= bound_q) begin
							le_q <= le_q + CW'(1);
						end
						if (!mt_found_q && e_off == off_q && e_col == col_q) begin
							mt_found_q <= 1'b1;
							mt_idx_q   <= src_m1;
						end
					end
					if (!rd_en && !rd_vld_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					case (op_q)
						OP_INSERT: begin
							// new stop goes after the last equal offset
							lo_q     <= le_q;
							rd_ptr_q <= cnt_q;
							state_q  <= S_SHIFT;
						end
						OP_REMOVE_INTERVAL, OP_REMOVE_OFFSET: begin
							if (le_q > lt_q) begin
								lo_q     <= lt_q;
								hi_q     <= le_q;
								wr_ptr_q <= lt_q;
								rd_ptr_q <= le_q;
								state_q  <= S_COPY;
							end else begin
								if (op_q == OP_REMOVE_OFFSET) begin
									status_q <= ST_INVALID;
								end
								state_q <= S_DONE;
							end
						end
						OP_REMOVE_STOP: begin
							if (mt_found_q) begin
								lo_q     <= mt_idx_q;
								hi_q     <= mt_idx_q + CW'(1);
								wr_ptr_q <= mt_idx_q;
								rd_ptr_q <= mt_idx_q + CW'(1);
								state_q  <= S_COPY;
							end else begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_DONE;
							end
						end
						OP_INDEX_OF: begin
							if (le_q > lt_q) begin
								found_q <= lt_q;
							end else begin
								status_q <= ST_NOT_FOUND;
							end
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_COPY: begin
					// entry read at rd_ptr lands at wr_ptr in the following cycle
					if (rd_vld_q) begin
						wr_ptr_q <= wr_ptr_q + CW'(1);
					end
					if (!rd_en && !rd_vld_q) begin
						cnt_q   <= cnt_q - (hi_q - lo_q);
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					// entry read at index k lands at k+1
					if (rd_en) begin
						wr_ptr_q <= rd_ptr_q;
					end
					if (!rd_en && !rd_vld_q) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_DONE);
	assign status      = status_q;
	assign found_index = found_q;
	assign stop_count  = cnt_q;

endmodule

[dv/gradient_stop_sorted_table_tb.sv]
// gradient_stop_sorted_table_tb: self-checking bench for the sorted gradient stop table
// depends on gsst_pkg and the gradient_stop_sorted_table rtl
`timescale 1ns / 100ps

module gradient_stop_sorted_table_tb;
	import gsst_pkg::*;

	localparam int N_STOPS    = 16;
	localparam int IDX_W      = 5;
	localparam int N_RANDOM   = 500;
	localparam int CYCLE_CAP  = 400000;

	typedef struct packed {
		op_t                 op;
		logic [OFFSET_W-1:0] offset;
		logic [OFFSET_W-1:0] offset_max;
		logic [IDX_W-1:0]    first_index;
		logic [IDX_W-1:0]    end_index;
		logic [31:0]         color;
	} word_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] found_index;
		logic [IDX_W-1:0] stop_count;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	op_t op = OP_CLEAR;
	logic [OFFSET_W-1:0] offset = '0;
	logic [OFFSET_W-1:0] offset_max = '0;
	logic [IDX_W-1:0] first_index = '0;
	logic [IDX_W-1:0] end_index = '0;
	logic [31:0] color = '0;
	logic done;
	status_t status;
	logic [IDX_W-1:0] found_index;
	logic [IDX_W-1:0] stop_count;

	gradient_stop_sorted_table u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .offset(offset), .offset_max(offset_max),
		.first_index(first_index), .end_index(end_index), .color(color),
		.done(done), .status(status), .found_index(found_index),
		.stop_count(stop_count)
	);

	always #1 clk = ~clk;

	// shadow copy of the table, updated as words are accepted
	logic [OFFSET_W-1:0] shadow_off [N_STOPS];
	logic [31:0]         shadow_col [N_STOPS];
	int                  shadow_cnt;

	word_t  pending_words [$];
	reply_t expected_replies [$];
	int     error_count = 0;
	int     cycle_count = 0;
	bit     calm_tail = 0;      // no idling near the end of the run
	int     send_gap = 0;

	// delete entries [lo, hi) and close the hole
	function automatic void table_drop(int lo, int hi);
		int r;
		r = lo;
		for (int w = hi; w < shadow_cnt; w++) begin
			shadow_off[r] = shadow_off[w];
			shadow_col[r] = shadow_col[w];
			r++;
		end
		shadow_cnt -= hi - lo;
	endfunction

	function automatic int table_first(logic [OFFSET_W-1:0] v);
		for (int i = 0; i < shadow_cnt; i++) begin
			if (shadow_off[i] > v) break;
			if (shadow_off[i] == v) return i;
		end
		return shadow_cnt;
	endfunction

	// apply one word to the shadow table and return the reply it must give
	function automatic reply_t table_apply(word_t w);
		reply_t rp;
		int i, j, e;
		rp.status = ST_OK;
		rp.found_index = IDX_W'(N_STOPS);
		case (w.op)
			OP_INSERT: begin
				if (w.offset > OFFSET_ONE) rp.status = ST_INVALID;
				else if (shadow_cnt >= N_STOPS) rp.status = ST_FULL;
				else begin
					// goes after the last stop of equal offset
					for (i = 0; i < shadow_cnt; i++)
						if (shadow_off[i] > w.offset) break;
					for (j = shadow_cnt; j > i; j--) begin
						shadow_off[j] = shadow_off[j-1];
						shadow_col[j] = shadow_col[j-1];
					end
					shadow_off[i] = w.offset;
					shadow_col[i] = w.color;
					shadow_cnt++;
				end
			end
			OP_REMOVE_AT: begin
				if (w.first_index >= shadow_cnt) rp.status = ST_INVALID;
				else table_drop(w.first_index, w.first_index + 1);
			end
			OP_REMOVE_RANGE: begin
				if (w.first_index >= shadow_cnt) rp.status = ST_INVALID;
				else begin
					e = (w.end_index > shadow_cnt) ? shadow_cnt : w.end_index;
					if (e > w.first_index) table_drop(w.first_index, e);
				end
			end
			OP_REMOVE_INTERVAL: begin
				if (w.offset > w.offset_max) rp.status = ST_INVALID;
				else begin
					for (i = 0; i < shadow_cnt; i++)
						if (shadow_off[i] >= w.offset) break;
					for (j = i; j < shadow_cnt; j++)
						if (shadow_off[j] > w.offset_max) break;
					if (j > i) table_drop(i, j);
				end
			end
			OP_REMOVE_OFFSET: begin
				i = table_first(w.offset);
				if (i >= shadow_cnt) rp.status = ST_INVALID;
				else begin
					for (j = i + 1; j < shadow_cnt; j++)
						if (shadow_off[j] != w.offset) break;
					table_drop(i, j);
				end
			end
			OP_REMOVE_STOP: begin
				if (w.offset > OFFSET_ONE) rp.status = ST_INVALID;
				else begin
					rp.status = ST_NOT_FOUND;
					for (i = 0; i < shadow_cnt; i++) begin
						if (shadow_off[i] < w.offset) continue;
						if (shadow_off[i] > w.offset) break;
						if (shadow_col[i] == w.color) begin
							table_drop(i, i + 1);
							rp.status = ST_OK;
							break;
						end
					end
				end
			end
			OP_INDEX_OF: begin
				i = table_first(w.offset);
				if (i < shadow_cnt) rp.found_index = IDX_W'(i);
				else rp.status = ST_NOT_FOUND;
			end
			default: shadow_cnt = 0;
		endcase
		rp.stop_count = IDX_W'(shadow_cnt);
		return rp;
	endfunction

	// offsets drawn from a small pool so that duplicates and hits are common
	function automatic logic [OFFSET_W-1:0] pick_offset();
		case ($urandom_range(0, 9))
			0: return OFFSET_ONE;
			1: return '0;
			2: return OFFSET_W'($urandom_range(65537, 131071));
			3: return OFFSET_W'($urandom_range(0, 65536));
			default: return OFFSET_W'($urandom_range(0, 7) * 8192);
		endcase
	endfunction

	// colors from a small pool too, with an occasional wide random one
	function automatic logic [31:0] pick_color();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return 32'($urandom_range(0, 3)) ^ {32{$urandom_range(0, 1) == 1}};
	endfunction

	function automatic word_t random_word();
		word_t w;
		int k;
		k = $urandom_range(0, 99);
		// inserts dominate so the table fills and reaches full often
		if (k < 40) w.op = OP_INSERT;
		else if (k < 98) w.op = op_t'($urandom_range(1, 6));
		else w.op = OP_CLEAR;
		w.offset      = pick_offset();
		w.offset_max  = ($urandom_range(0, 4) == 0) ? pick_offset()
		                : OFFSET_W'(w.offset + $urandom_range(0, 20000));
		w.first_index = IDX_W'($urandom_range(0, 31));
		w.end_index   = IDX_W'($urandom_range(0, 31));
		if ($urandom_range(0, 2) != 0) begin
			w.first_index = IDX_W'($urandom_range(0, 16));
			w.end_index   = IDX_W'($urandom_range(0, 17));
		end
		w.color = pick_color();
		return w;
	endfunction

	function automatic word_t make_word(op_t o, int off, int offm, int fi, int ei,
	                                   logic [31:0] col);
		word_t w;
		w.op = o;
		w.offset = OFFSET_W'(off);
		w.offset_max = OFFSET_W'(offm);
		w.first_index = IDX_W'(fi);
		w.end_index = IDX_W'(ei);
		w.color = col;
		return w;
	endfunction

	// driver: one word in flight on the bus, random gaps between words
	always @(posedge clk) begin
		word_t w;
		if (arst_n) begin
			if (start && !busy) begin
				expected_replies.push_back(table_apply(pending_words.pop_front()));
			end
			if (start && busy) begin
				// keep holding the current word
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				start <= 1'b0;
			end else if (pending_words.size() > 0 && !(start && !busy
			             && pending_words.size() == 0)) begin
				if (!calm_tail && $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(1, 15) - 1;
					start <= 1'b0;
				end else begin
					w = pending_words[0];
					op <= w.op;
					offset <= w.offset;
					offset_max <= w.offset_max;
					first_index <= w.first_index;
					end_index <= w.end_index;
					color <= w.color;
					start <= 1'b1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare every reply word with the oldest expectation
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected reply status=%0d found=%0d count=%0d",
				         $time, status, found_index, stop_count);
				error_count++;
			end else begin
				want = expected_replies.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
					         $time, want.status, status);
					error_count++;
				end
				if (found_index !== want.found_index) begin
					$display("%0t: found_index expected %0d actual %0d",
					         $time, want.found_index, found_index);
					error_count++;
				end
				if (stop_count !== want.stop_count) begin
					$display("%0t: stop_count expected %0d actual %0d",
					         $time, want.stop_count, stop_count);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		shadow_cnt = 0;
		for (int i = 0; i < N_STOPS; i++) begin
			shadow_off[i] = '0;
			shadow_col[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed part: empty-table cases, equal offsets, full table, each op
		pending_words.push_back(make_word(OP_INDEX_OF, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(OP_REMOVE_AT, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(OP_REMOVE_INTERVAL, 0, 131071, 0, 0, 0));
		pending_words.push_back(make_word(OP_INSERT, 65537, 0, 0, 0, 32'hFFFF_FFFF));
		pending_words.push_back(make_word(OP_INSERT, 131071, 0, 0, 0, 0));
		for (int i = 0; i < 17; i++)
			pending_words.push_back(make_word(OP_INSERT, (i % 3) * 32768, 0, 0, 0,
			                                  (i[0]) ? 32'hFFFF_FFFF : 32'(i)));
		pending_words.push_back(make_word(OP_INDEX_OF, 65536, 0, 0, 0, 0));
		pending_words.push_back(make_word(OP_REMOVE_STOP, 32768, 0, 0, 0, 32'hFFFF_FFFF));
		pending_words.push_back(make_word(OP_REMOVE_STOP, 32768, 0, 0, 0, 32'h1234));
		pending_words.push_back(make_word(OP_REMOVE_STOP, 131071, 0, 0, 0, 0));
		pending_words.push_back(make_word(OP_REMOVE_OFFSET, 131071, 0, 0, 0, 0));
		pending_words.push_back(make_word(OP_REMOVE_OFFSET, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(OP_REMOVE_RANGE, 0, 0, 5, 3, 0));
		pending_words.push_back(make_word(OP_REMOVE_RANGE, 0, 0, 31, 31, 0));
		pending_words.push_back(make_word(OP_REMOVE_INTERVAL, 9, 8, 0, 0, 0));
		pending_words.push_back(make_word(OP_REMOVE_RANGE, 0, 0, 1, 31, 0));
		pending_words.push_back(make_word(OP_REMOVE_AT, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(OP_CLEAR, 0, 0, 0, 0, 0));

		for (int n = 0; n < N_RANDOM; n++) begin
			pending_words.push_back(random_word());
			if (n == N_RANDOM - 60) begin
				wait (pending_words.size() < 60);
				calm_tail = 1;
			end
		end

		wait (pending_words.size() == 0 && !start && expected_replies.size() == 0);
		repeat (60) @(posedge clk);
		if (error_count == 0 && expected_replies.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
